>>> rtl/frequency_count_table_assert.svh
// Assertion macros for the frequency count table.
`ifndef FREQUENCY_COUNT_TABLE_ASSERT_SVH
`define FREQUENCY_COUNT_TABLE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define FCT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define FCT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/fct_pkg.sv
package fct_pkg;

	localparam int IN_KEY_W    = 16;
	localparam int LIMIT_W     = 17;
	localparam int AMT_W       = 16;
	localparam int OUT_CNT_W   = 32;
	localparam int OUT_KEY_W   = 16;
	localparam int MAX_RESULTS = 64;
	localparam int RANK_W      = 7;

	typedef enum logic [2:0] {
		REQ_INC   = 3'd0,
		REQ_DEC   = 3'd1,
		REQ_REM   = 3'd2,
		REQ_COUNT = 3'd3,
		REQ_RANGE = 3'd4,
		REQ_TOTAL = 3'd5,
		REQ_MOST  = 3'd6,
		REQ_LEAST = 3'd7
	} req_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_APPLY,
		ST_RANK
	} state_t;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} mem_ctl_t;

endpackage

>>> rtl/fct_mem.sv
module fct_mem #(
	parameter int DEPTH = 64,
	parameter int KW    = 16,
	parameter int CW    = 32
) (
	input  logic                     clk,
	input  fct_pkg::mem_ctl_t        ctl,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [KW-1:0]            wr_key,
	input  logic [CW-1:0]            wr_cnt,
	output logic [KW-1:0]            rd_key,
	output logic [CW-1:0]            rd_cnt
);

	logic [KW-1:0] key_mem [DEPTH];
	logic [CW-1:0] cnt_mem [DEPTH];

	// write one entry
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			key_mem[wr_addr] <= wr_key;
			cnt_mem[wr_addr] <= wr_cnt;
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rd_key <= key_mem[rd_addr];
			rd_cnt <= cnt_mem[rd_addr];
		end
	end

endmodule

>>> rtl/frequency_count_table.sv
// Frequency count table: start is taken when busy is low, and busy then stays
// high until the request's last result has been shown. Every request scans the
// whole key/count memory, one entry read per cycle; a request other than a
// ranking gives a single result. A ranking that lists n keys runs one scan per
// key, with one result per scan. Each result sits on the outputs for exactly one
// cycle under done, with last marking the final one; the receiver cannot stall,
// so it must take every result in the cycle it appears.
`include "frequency_count_table_assert.svh"

module frequency_count_table #(
	parameter int ENTRIES    = 64,
	parameter int KEY_BITS   = 16,
	parameter int COUNT_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [2:0]                    req_type,
	input  logic [fct_pkg::IN_KEY_W-1:0]  key,
	input  logic [fct_pkg::LIMIT_W-1:0]   key_limit,
	input  logic [fct_pkg::AMT_W-1:0]     amount,
	output logic                          busy,
	output logic                          done,
	output logic [fct_pkg::OUT_CNT_W-1:0] count_value,
	output logic [fct_pkg::OUT_KEY_W-1:0] result_key,
	output logic                          has_key,
	output logic                          insert_dropped,
	output logic                          last
);

	localparam int AW = $clog2(ENTRIES);
	localparam int NW = $clog2(ENTRIES + 1);
	localparam int SW = COUNT_BITS + 17;
	localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};
	localparam logic [AW-1:0] LAST_IDX = AW'(ENTRIES - 1);

	function automatic logic [COUNT_BITS-1:0] sat_add(input logic [COUNT_BITS-1:0] a,
		input logic [SW-1:0] b);
		logic [SW-1:0] s;
		s = SW'(a) + b;
		if (s > SW'(CMAX)) return CMAX;
		return s[COUNT_BITS-1:0];
	endfunction

	fct_pkg::state_t state_q, state_d;
	fct_pkg::req_t   req_q;
	logic [KEY_BITS-1:0]             key_q;
	logic [fct_pkg::LIMIT_W-1:0]     lim_q;
	logic [fct_pkg::AMT_W-1:0]       amt_q;
	logic [ENTRIES-1:0]              valid_q, listed_q;

	logic [AW-1:0] addr_q;
	logic          issue_q;
	logic          rd_s1;
	logic [AW-1:0] idx_s1;
	logic [KEY_BITS-1:0]   rd_key_s1;
	logic [COUNT_BITS-1:0] rd_cnt_s1;

	logic                  hit_q, free_found_q, best_found_q, first_pass_q;
	logic [AW-1:0]         hit_idx_q, free_idx_q, best_idx_q;
	logic [COUNT_BITS-1:0] hit_cnt_q, sum_q, best_cnt_q;
	logic [KEY_BITS-1:0]   best_key_q;
	logic [NW-1:0]         nvalid_q;
	logic [fct_pkg::RANK_W-1:0] want_q, nlist_q;

	logic [63:0]         key_ext;
	logic [KEY_BITS-1:0] key_in;
	logic accept, scan_go, scan_end;
	logic ent_v, ent_l, match, in_range, better;

	logic                  emit, e_has, e_drop, e_last;
	logic [COUNT_BITS-1:0] e_cnt;
	logic [KEY_BITS-1:0]   e_key;
	fct_pkg::mem_ctl_t     mctl;
	logic [AW-1:0]         wr_addr;
	logic [KEY_BITS-1:0]   wr_key;
	logic [COUNT_BITS-1:0] wr_cnt;
	logic                  set_valid, clr_valid, set_listed;
	logic [AW-1:0]         flag_idx;
	logic [fct_pkg::RANK_W-1:0] want_now;
	logic [16:0]           want_w;
	logic [63:0]           cnt_ext, okey_ext;

	assign key_ext = 64'(key);
	assign key_in  = key_ext[KEY_BITS-1:0];
	assign busy    = (state_q != fct_pkg::ST_IDLE);
	assign accept  = start && !busy;

	// memory holds keys and counts; reads stream during a scan
	fct_mem #(.DEPTH(ENTRIES), .KW(KEY_BITS), .CW(COUNT_BITS)) u_mem (
		.clk     (clk),
		.ctl     (mctl),
		.rd_addr (addr_q),
		.wr_addr (wr_addr),
		.wr_key  (wr_key),
		.wr_cnt  (wr_cnt),
		.rd_key  (rd_key_s1),
		.rd_cnt  (rd_cnt_s1)
	);

	// per-entry evaluation of the word returned by the memory
	always_comb begin
		ent_v    = valid_q[idx_s1];
		ent_l    = listed_q[idx_s1];
		match    = ent_v && (rd_key_s1 == key_q);
		in_range = (req_q == fct_pkg::REQ_TOTAL) ||
			((rd_key_s1 >= key_q) && (65'(rd_key_s1) < 65'(lim_q)));
		if (rd_cnt_s1 == best_cnt_q) better = rd_key_s1 < best_key_q;
		else if (req_q == fct_pkg::REQ_MOST) better = rd_cnt_s1 > best_cnt_q;
		else better = rd_cnt_s1 < best_cnt_q;
		scan_end = rd_s1 && (idx_s1 == LAST_IDX);
	end

	// ranking length: smaller of request, valid entries and result limit
	always_comb begin
		want_w = 17'(amt_q);
		if (want_w > 17'(nvalid_q)) want_w = 17'(nvalid_q);
		if (want_w > 17'(fct_pkg::MAX_RESULTS)) want_w = 17'(fct_pkg::MAX_RESULTS);
		want_now = first_pass_q ? want_w[fct_pkg::RANK_W-1:0] : want_q;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fct_pkg::ST_IDLE:  if (start) state_d = fct_pkg::ST_SCAN;
			fct_pkg::ST_SCAN: begin
				if (scan_end) begin
					if (req_q == fct_pkg::REQ_MOST || req_q == fct_pkg::REQ_LEAST)
						state_d = fct_pkg::ST_RANK;
					else
						state_d = fct_pkg::ST_APPLY;
				end
			end
			fct_pkg::ST_APPLY: state_d = fct_pkg::ST_IDLE;
			fct_pkg::ST_RANK:  state_d = e_last ? fct_pkg::ST_IDLE : fct_pkg::ST_SCAN;
			default:           state_d = fct_pkg::ST_IDLE;
		endcase
	end

	// outputs: result, write-back and flag updates
	always_comb begin
		emit       = 1'b0;
		e_cnt      = '0;
		e_key      = '0;
		e_has      = 1'b0;
		e_drop     = 1'b0;
		e_last     = 1'b0;
		mctl.rd_en = issue_q;
		mctl.wr_en = 1'b0;
		wr_addr    = hit_idx_q;
		wr_key     = key_q;
		wr_cnt     = hit_cnt_q;
		set_valid  = 1'b0;
		clr_valid  = 1'b0;
		set_listed = 1'b0;
		flag_idx   = hit_idx_q;
		scan_go    = accept;
		unique case (state_q)
			fct_pkg::ST_APPLY: begin
				emit   = 1'b1;
				e_last = 1'b1;
				case (req_q)
					fct_pkg::REQ_INC: begin
						if (hit_q) begin
							wr_cnt     = sat_add(hit_cnt_q, SW'(amt_q));
							mctl.wr_en = 1'b1;
							e_cnt      = wr_cnt;
						end else if (free_found_q) begin
							wr_addr    = free_idx_q;
							flag_idx   = free_idx_q;
							wr_cnt     = sat_add('0, SW'(amt_q));
							mctl.wr_en = 1'b1;
							set_valid  = 1'b1;
							e_cnt      = wr_cnt;
						end else begin
							e_drop = 1'b1;
						end
					end
					fct_pkg::REQ_DEC: begin
						if (hit_q) begin
							if (64'(hit_cnt_q) > 64'(amt_q)) begin
								wr_cnt     = hit_cnt_q - COUNT_BITS'(amt_q);
								mctl.wr_en = 1'b1;
								e_cnt      = wr_cnt;
							end else begin
								clr_valid = 1'b1;
							end
						end
					end
					fct_pkg::REQ_REM:   clr_valid = hit_q;
					fct_pkg::REQ_COUNT: e_cnt = hit_q ? hit_cnt_q : '0;
					default:            e_cnt = sum_q;
				endcase
			end
			fct_pkg::ST_RANK: begin
				emit = 1'b1;
				if (want_now == '0 || !best_found_q) begin
					e_last = 1'b1;
				end else begin
					e_cnt      = best_cnt_q;
					e_key      = best_key_q;
					e_has      = 1'b1;
					e_last     = (nlist_q + 1'b1) == want_now;
					set_listed = 1'b1;
					flag_idx   = best_idx_q;
					scan_go    = !e_last;
				end
			end
			default: ;
		endcase
	end

	assign cnt_ext  = 64'(e_cnt);
	assign okey_ext = 64'(e_key);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= fct_pkg::ST_IDLE;
			valid_q  <= '0;
			listed_q <= '0;
			issue_q  <= 1'b0;
			rd_s1    <= 1'b0;
			done     <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_s1   <= issue_q;
			done    <= emit;
			if (scan_go) issue_q <= 1'b1;
			else if (issue_q && addr_q == LAST_IDX) issue_q <= 1'b0;
			// start of a ranking forgets earlier listings
			if (accept && (req_type == fct_pkg::REQ_MOST || req_type == fct_pkg::REQ_LEAST))
				listed_q <= '0;
			if (set_valid) begin
				valid_q[flag_idx]  <= 1'b1;
				listed_q[flag_idx] <= 1'b0;
			end
			if (clr_valid) valid_q[flag_idx] <= 1'b0;
			if (set_listed) listed_q[flag_idx] <= 1'b1;
		end
	end

	// request fields, scan address and accumulators
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q        <= fct_pkg::req_t'(req_type);
			key_q        <= key_in;
			lim_q        <= key_limit;
			amt_q        <= amount;
			first_pass_q <= 1'b1;
			nlist_q      <= '0;
		end
		idx_s1 <= addr_q;
		if (scan_go) begin
			addr_q       <= '0;
			hit_q        <= 1'b0;
			free_found_q <= 1'b0;
			best_found_q <= 1'b0;
			sum_q        <= '0;
			nvalid_q     <= '0;
		end else if (issue_q) begin
			addr_q <= addr_q + 1'b1;
		end
		if (rd_s1) begin
			if (match) begin
				hit_q     <= 1'b1;
				hit_idx_q <= idx_s1;
				hit_cnt_q <= rd_cnt_s1;
			end
			if (!ent_v && !free_found_q) begin
				free_found_q <= 1'b1;
				free_idx_q   <= idx_s1;
			end
			if (ent_v && in_range) sum_q <= sat_add(sum_q, SW'(rd_cnt_s1));
			if (ent_v) nvalid_q <= nvalid_q + 1'b1;
			if (ent_v && !ent_l && (!best_found_q || better)) begin
				best_found_q <= 1'b1;
				best_idx_q   <= idx_s1;
				best_key_q   <= rd_key_s1;
				best_cnt_q   <= rd_cnt_s1;
			end
		end
		if (state_q == fct_pkg::ST_RANK) begin
			want_q       <= want_now;
			first_pass_q <= 1'b0;
			nlist_q      <= nlist_q + 1'b1;
		end
		if (emit) begin
			count_value    <= cnt_ext[fct_pkg::OUT_CNT_W-1:0];
			result_key     <= okey_ext[fct_pkg::OUT_KEY_W-1:0];
			has_key        <= e_has;
			insert_dropped <= e_drop;
			last           <= e_last;
		end
	end

	`FCT_ASSERT_NOW(a_last_frees, done && last, !busy, "busy after last item")
	`FCT_ASSERT_NOW(a_more_busy, done && !last, busy, "idle with items pending")
	`FCT_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted request not busy")
	`FCT_ASSERT_NOW(a_drop_single, done && insert_dropped, last && !has_key,
		"dropped insert not a single item")

endmodule

>>> dv/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS       = 64;
	localparam int RAND_ITEMS  = 460;
	localparam int CALM_ITEMS  = 80;
	localparam int KEY_POOL    = 90;
	localparam int CYCLE_LIMIT = 10000000;

	typedef struct {
		fct_pkg::req_t op;
		bit [15:0] key;
		bit [16:0] lim;
		bit [15:0] amt;
	} request_t;

	typedef struct {
		bit [31:0] cnt;
		bit [15:0] rkey;
		bit        has;
		bit        dropped;
		bit        last;
	} answer_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic [2:0]  req_type;
	logic [15:0] key;
	logic [16:0] key_limit;
	logic [15:0] amount;
	logic        busy;
	logic        done;
	logic [31:0] count_value;
	logic [15:0] result_key;
	logic        has_key;
	logic        insert_dropped;
	logic        last;

	frequency_count_table i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.req_type      (req_type),
		.key           (key),
		.key_limit     (key_limit),
		.amount        (amount),
		.busy          (busy),
		.done          (done),
		.count_value   (count_value),
		.result_key    (result_key),
		.has_key       (has_key),
		.insert_dropped(insert_dropped),
		.last          (last)
	);

	// predicted table contents
	bit        tbl_valid [SLOTS];
	bit [15:0] tbl_key   [SLOTS];
	bit [31:0] tbl_count [SLOTS];

	request_t  pending_q[$];
	answer_t   answer_q[$];
	bit [15:0] key_pool[KEY_POOL];

	int  gap_left;
	bit  stim_done;
	int  errors;
	int  items_taken;
	int  answers_seen;
	int  drops_seen;
	int  keys_listed;
	longint cycles;

	function automatic bit [31:0] sat_sum(bit [31:0] a, bit [31:0] b);
		bit [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	function automatic answer_t mk_answer(bit [31:0] c, bit [15:0] k, bit h, bit d, bit l);
		answer_t a;
		a.cnt = c; a.rkey = k; a.has = h; a.dropped = d; a.last = l;
		return a;
	endfunction

	// append one expected result item
	function automatic void add_answer(answer_t a);
		answer_q.insert(answer_q.size(), a);
	endfunction

	// apply one request to the table copy and queue its answers
	task automatic predict_request(request_t r);
		int        hit;
		int        free_slot;
		int        live;
		int        want;
		int        best;
		bit        better;
		bit        listed [SLOTS];
		bit [31:0] acc;
		hit = -1;
		free_slot = -1;
		live = 0;
		for (int i = 0; i < SLOTS; i++) begin
			if (tbl_valid[i] && tbl_key[i] == r.key && hit < 0)
				hit = i;
			if (!tbl_valid[i] && free_slot < 0)
				free_slot = i;
			if (tbl_valid[i])
				live++;
			listed[i] = 0;
		end
		case (r.op)
			fct_pkg::REQ_INC: begin
				if (hit >= 0) begin
					tbl_count[hit] = sat_sum(tbl_count[hit], 32'(r.amt));
					add_answer(mk_answer(tbl_count[hit], 0, 0, 0, 1));
				end else if (free_slot >= 0) begin
					tbl_valid[free_slot] = 1;
					tbl_key[free_slot] = r.key;
					tbl_count[free_slot] = 32'(r.amt);
					add_answer(mk_answer(32'(r.amt), 0, 0, 0, 1));
				end else begin
					add_answer(mk_answer(0, 0, 0, 1, 1));
				end
			end
			fct_pkg::REQ_DEC: begin
				if (hit >= 0 && tbl_count[hit] > 32'(r.amt)) begin
					tbl_count[hit] -= 32'(r.amt);
					add_answer(mk_answer(tbl_count[hit], 0, 0, 0, 1));
				end else begin
					if (hit >= 0)
						tbl_valid[hit] = 0;
					add_answer(mk_answer(0, 0, 0, 0, 1));
				end
			end
			fct_pkg::REQ_REM: begin
				if (hit >= 0)
					tbl_valid[hit] = 0;
				add_answer(mk_answer(0, 0, 0, 0, 1));
			end
			fct_pkg::REQ_COUNT: begin
				add_answer(mk_answer(hit >= 0 ? tbl_count[hit] : 0, 0, 0, 0, 1));
			end
			fct_pkg::REQ_RANGE, fct_pkg::REQ_TOTAL: begin
				acc = 0;
				for (int i = 0; i < SLOTS; i++)
					if (tbl_valid[i] && (r.op == fct_pkg::REQ_TOTAL ||
							(tbl_key[i] >= r.key && 17'(tbl_key[i]) < r.lim)))
						acc = sat_sum(acc, tbl_count[i]);
				add_answer(mk_answer(acc, 0, 0, 0, 1));
			end
			default: begin
				want = int'(r.amt);
				if (want > live)
					want = live;
				if (want == 0)
					add_answer(mk_answer(0, 0, 0, 0, 1));
				for (int n = 0; n < want; n++) begin
					best = -1;
					for (int i = 0; i < SLOTS; i++) begin
						if (!tbl_valid[i] || listed[i])
							continue;
						if (best < 0) begin
							best = i;
							continue;
						end
						if (tbl_count[i] == tbl_count[best])
							better = tbl_key[i] < tbl_key[best];
						else if (r.op == fct_pkg::REQ_MOST)
							better = tbl_count[i] > tbl_count[best];
						else
							better = tbl_count[i] < tbl_count[best];
						if (better)
							best = i;
					end
					listed[best] = 1;
					add_answer(mk_answer(tbl_count[best], tbl_key[best], 1, 0,
						n == want - 1));
				end
			end
		endcase
	endtask

	task automatic queue_item(fct_pkg::req_t op, bit [15:0] k, bit [16:0] lim,
		bit [15:0] amt);
		request_t r;
		r.op = op; r.key = k; r.lim = lim; r.amt = amt;
		pending_q.insert(pending_q.size(), r);
	endtask

	function automatic request_t random_item(int idx);
		request_t r;
		int       pick;
		pick = (idx < 150) ? $urandom_range(0, 99) : $urandom_range(0, 99);
		// lean on inserts early so the table fills up
		if (idx < 150 && pick < 40)
			pick = 0;
		r.key = ($urandom_range(0, 9) == 0) ? 16'($urandom) :
			key_pool[$urandom_range(0, KEY_POOL - 1)];
		r.lim = 17'($urandom_range(0, 65536));
		r.amt = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
		if (pick < 45)
			r.op = fct_pkg::REQ_INC;
		else if (pick < 62)
			r.op = fct_pkg::REQ_DEC;
		else if (pick < 68)
			r.op = fct_pkg::REQ_REM;
		else if (pick < 78)
			r.op = fct_pkg::REQ_COUNT;
		else if (pick < 86)
			r.op = fct_pkg::REQ_RANGE;
		else if (pick < 90)
			r.op = fct_pkg::REQ_TOTAL;
		else
			r.op = (pick < 95) ? fct_pkg::REQ_MOST : fct_pkg::REQ_LEAST;
		if (r.op == fct_pkg::REQ_RANGE && $urandom_range(0, 1)) begin
			r.lim = 17'(r.key) + 17'($urandom_range(0, 20000));
			if (r.lim > 65536)
				r.lim = 65536;
		end
		// rankings mostly short; a rare long one covers the whole table
		if (r.op == fct_pkg::REQ_MOST || r.op == fct_pkg::REQ_LEAST)
			r.amt = ($urandom_range(0, 19) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
		return r;
	endfunction

	// clock and reset
	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
	end

	// driver: present pending items at the falling edge
	always @(negedge clk) begin
		if (!arst_n || gap_left > 0 || pending_q.size() == 0) begin
			start <= 0;
			if (arst_n && gap_left > 0 && !busy)
				gap_left <= gap_left - 1;
		end else begin
			start     <= 1;
			req_type  <= pending_q[0].op;
			key       <= pending_q[0].key;
			key_limit <= pending_q[0].lim;
			amount    <= pending_q[0].amt;
		end
	end

	// monitor: check results, take accepted items into the predictor
	always @(posedge clk) begin
		answer_t want_a;
		cycles <= cycles + 1;
		if (arst_n && done) begin
			answers_seen <= answers_seen + 1;
			if (insert_dropped)
				drops_seen <= drops_seen + 1;
			if (has_key)
				keys_listed <= keys_listed + 1;
			if (answer_q.size() == 0) begin
				$display("%0t: unexpected item cnt=%0d key=%0d has=%0b drop=%0b last=%0b",
					$time, count_value, result_key, has_key, insert_dropped, last);
				errors <= errors + 1;
			end else begin
				want_a = answer_q.pop_front();
				if (count_value !== want_a.cnt || result_key !== want_a.rkey ||
						has_key !== want_a.has || insert_dropped !== want_a.dropped ||
						last !== want_a.last) begin
					$display("%0t: mismatch expected cnt=%0d key=%0d has=%0b drop=%0b last=%0b",
						$time, want_a.cnt, want_a.rkey, want_a.has, want_a.dropped,
						want_a.last);
					$display("%0t:          actual   cnt=%0d key=%0d has=%0b drop=%0b last=%0b",
						$time, count_value, result_key, has_key, insert_dropped, last);
					errors <= errors + 1;
				end
			end
		end
		if (arst_n && start && !busy && pending_q.size() > 0) begin
			predict_request(pending_q.pop_front());
			items_taken <= items_taken + 1;
			if (pending_q.size() > CALM_ITEMS && $urandom_range(0, 3) == 0)
				gap_left <= $urandom_range(1, 19);
		end
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d items pending", $time, pending_q.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// stimulus and end of run
	initial begin
		start = 0;
		req_type = fct_pkg::REQ_INC;
		key = 0;
		key_limit = 0;
		amount = 0;
		gap_left = 0;
		errors = 0;
		items_taken = 0;
		answers_seen = 0;
		drops_seen = 0;
		keys_listed = 0;
		cycles = 0;
		for (int i = 0; i < SLOTS; i++)
			tbl_valid[i] = 0;
		for (int i = 0; i < KEY_POOL; i++)
			key_pool[i] = 16'($urandom);
		key_pool[0] = 16'h0000;
		key_pool[1] = 16'hFFFF;

		// empty table: rankings, total, decrement and removal of absent keys
		queue_item(fct_pkg::REQ_MOST, 16'h0001, 0, 16'd5);
		queue_item(fct_pkg::REQ_LEAST, 16'h0001, 0, 16'd0);
		queue_item(fct_pkg::REQ_TOTAL, 16'h0000, 0, 16'd0);
		queue_item(fct_pkg::REQ_DEC, 16'h0007, 0, 16'd1);
		queue_item(fct_pkg::REQ_REM, 16'h0007, 0, 16'd1);
		// inserts, zero amount included, an update, then count queries
		queue_item(fct_pkg::REQ_INC, 16'h0000, 0, 16'd0);
		queue_item(fct_pkg::REQ_INC, 16'hFFFF, 0, 16'hFFFF);
		queue_item(fct_pkg::REQ_INC, 16'h5555, 0, 16'hAAAA);
		queue_item(fct_pkg::REQ_INC, 16'hAAAA, 0, 16'd1);
		queue_item(fct_pkg::REQ_INC, 16'h5555, 0, 16'd3);
		queue_item(fct_pkg::REQ_INC, 16'h0100, 0, 16'd3);
		queue_item(fct_pkg::REQ_INC, 16'h0010, 0, 16'd3);
		queue_item(fct_pkg::REQ_COUNT, 16'h5555, 0, 16'd0);
		queue_item(fct_pkg::REQ_COUNT, 16'h1234, 0, 16'd0);
		// full range, empty range, range of the top key alone
		queue_item(fct_pkg::REQ_RANGE, 16'h0000, 17'd65536, 16'd0);
		queue_item(fct_pkg::REQ_RANGE, 16'd100, 17'd100, 16'd0);
		queue_item(fct_pkg::REQ_RANGE, 16'hFFFF, 17'h1FFFF & 17'd65536, 16'd0);
		// ties go to the smaller key
		queue_item(fct_pkg::REQ_MOST, 16'h0000, 0, 16'hFFFF);
		queue_item(fct_pkg::REQ_LEAST, 16'h0000, 0, 16'd4);
		// decrement to zero, partial decrement, decrement below zero, then a removal and a total
		queue_item(fct_pkg::REQ_DEC, 16'hAAAA, 0, 16'd1);
		queue_item(fct_pkg::REQ_DEC, 16'hFFFF, 0, 16'hFFFE);
		queue_item(fct_pkg::REQ_DEC, 16'h5555, 0, 16'hFFFF);
		queue_item(fct_pkg::REQ_REM, 16'h0000, 0, 16'd0);
		queue_item(fct_pkg::REQ_TOTAL, 16'h0000, 0, 16'd0);

		for (int i = 0; i < RAND_ITEMS; i++)
			pending_q.insert(pending_q.size(), random_item(i));

		wait (pending_q.size() == 0);
		while (answer_q.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		$display("Ran %0d requests, checked %0d result items", items_taken, answers_seen);
		$display("Ranked keys listed: %0d, inserts dropped on a full table: %0d",
			keys_listed, drops_seen);
		if (errors == 0 && answer_q.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
